// ----- rtl/imuyaw_pkg.sv -----
// ----------------------------------------------------------------------------
// imuyaw_pkg
// shared types and constants for the imu bias calibration and yaw integration
// block: word layouts, command and register codes, controller states
// ----------------------------------------------------------------------------
package imuyaw_pkg;

	localparam int NUM_AXES   = 6;
	localparam int NUM_PAIRS  = NUM_AXES / 2;
	localparam int PAIR_W     = $clog2(NUM_PAIRS);
	localparam int AXIS_W     = 16;
	localparam int SUM_W      = 32;
	localparam int YAW_W      = 32;
	localparam int CNT_W      = 11;
	localparam int DB_W       = 15;
	localparam int DIVISOR_W  = 20;
	localparam int GAIN_W     = 16;
	localparam int STEP_W     = 8;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int DIV_CNT_W  = $clog2(YAW_W + 1);
	localparam int DELTA_W    = AXIS_W + STEP_W + 1;
	localparam int PROD_W     = YAW_W + GAIN_W;

	// command codes, the unused code acts as a sample
	localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESET_REL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START_CAL = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd2;

	localparam logic [DB_W-1:0]             DEADBAND_RST = 15'd19;
	localparam logic [DIVISOR_W-1:0]        DIVISOR_RST  = 20'd131000;
	localparam logic signed [GAIN_W-1:0]    GAIN_RST     = 16'sd1;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [AXIS_W-1:0] accel_x_raw;
		logic signed [AXIS_W-1:0] accel_y_raw;
		logic signed [AXIS_W-1:0] accel_z_raw;
		logic signed [AXIS_W-1:0] gyro_x_raw;
		logic signed [AXIS_W-1:0] gyro_y_raw;
		logic signed [AXIS_W-1:0] gyro_z_raw;
		logic [STEP_W-1:0]        step_time;
	} sample_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x_out;
		logic signed [AXIS_W-1:0] accel_y_out;
		logic signed [AXIS_W-1:0] accel_z_out;
		logic signed [AXIS_W-1:0] gyro_x_out;
		logic signed [AXIS_W-1:0] gyro_y_out;
		logic signed [AXIS_W-1:0] gyro_z_out;
		logic signed [YAW_W-1:0]  relative_yaw;
		logic signed [YAW_W-1:0]  relative_yaw_scaled;
		logic signed [AXIS_W-1:0] absolute_yaw_low;
		logic                     calibrating;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_CAL_START,
		ST_CAL_WAIT,
		ST_CORR,
		ST_INTEG,
		ST_YDIV_START,
		ST_YDIV_WAIT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic update;
		logic cal_start;
		logic cal_write;
		logic corr;
		logic integ;
		logic ydiv_start;
		logic ydiv_write;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cal_div;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ----- rtl/imu_bias_calibrate_yaw_integrate_unit.sv -----
// ----------------------------------------------------------------------------
// imu_bias_calibrate_yaw_integrate_unit
// six-axis bias calibration and yaw integration for one imu sample stream
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_ready  sample_t (cmd, 6 axes, step)
//  result    out        result_valid / result_ready  result_t (6 axes, yaw, flag)
//  config    in         cfg_we (no wait)             cfg_index, cfg_data
//
//  one word at a time; a normal word passes state update, axis correction, yaw
//    integration and the two 32-step serial dividers that scale both yaw sums
//  the word that ends a calibration run adds three offset division rounds,
//    run on the same two dividers
//  result sits in an output register: the next word is accepted while it waits
//  a stalled result only holds the controller in its final state
//  reset clears offsets, sums, counters and both yaw accumulators at once
//
module imu_bias_calibrate_yaw_integrate_unit #(
	parameter int CALIB_SAMPLES = 256,
	parameter int CALIB_DISCARD = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample words
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  imuyaw_pkg::sample_t                   sample,
	// result words
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output imuyaw_pkg::result_t                   result,
	// configuration writes, only while idle
	input  logic                                  cfg_we,
	input  logic [imuyaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imuyaw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import imuyaw_pkg::*;

	dp_cmd_t     dp_cmd;
	dp_status_t  dp_status;

	// sequencer: one state per step of a word
	imuyaw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (dp_status),
		.cmd          (dp_cmd)
	);

	// datapath: offsets, sums, accumulators, dividers, result register
	imuyaw_dp #(
		.CALIB_SAMPLES (CALIB_SAMPLES),
		.CALIB_DISCARD (CALIB_DISCARD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- rtl/imuyaw_div.sv -----
// ----------------------------------------------------------------------------
// imuyaw_div
// serial signed divider: signed dividend over a nonzero unsigned divisor,
// one quotient bit per cycle, quotient truncated toward zero
// ----------------------------------------------------------------------------
module imuyaw_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [imuyaw_pkg::YAW_W-1:0]     dividend,
	input  logic [imuyaw_pkg::DIVISOR_W-1:0]        divisor,
	output logic                                    done,
	output logic signed [imuyaw_pkg::YAW_W-1:0]     quotient
);
	import imuyaw_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  neg_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [YAW_W-1:0]      quo_q;
	logic [DIVISOR_W:0]    trial_w;
	logic [DIVISOR_W:0]    diff_w;
	logic                  fits_w;

	assign trial_w = {rem_q, quo_q[YAW_W-1]};
	assign diff_w  = trial_w - {1'b0, dsr_q};
	assign fits_w  = trial_w >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(YAW_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitude in, sign restored at the end
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[YAW_W-1];
			quo_q <= dividend[YAW_W-1] ? YAW_W'(-dividend) : YAW_W'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits_w ? diff_w[DIVISOR_W-1:0] : trial_w[DIVISOR_W-1:0];
			quo_q <= {quo_q[YAW_W-2:0], fits_w};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? signed'(-quo_q) : signed'(quo_q);

endmodule

// ----- rtl/imuyaw_ctrl.sv -----
// ----------------------------------------------------------------------------
// imuyaw_ctrl
// sequencer for one word: state update, optional offset divisions, axis
// correction, yaw integration, yaw divisions, result load
// ----------------------------------------------------------------------------
module imuyaw_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  imuyaw_pkg::dp_status_t   status,
	output imuyaw_pkg::dp_cmd_t      cmd
);
	import imuyaw_pkg::*;

	localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(NUM_PAIRS - 1);

	state_t             state_q;
	state_t             state_d;
	logic [PAIR_W-1:0]  pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				pair_q <= '0;
			end else if (cmd.cal_write) begin
				pair_q <= pair_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = status.cal_div ? ST_CAL_START : ST_CORR;
			end
			ST_CAL_START: begin
				state_d = ST_CAL_WAIT;
			end
			ST_CAL_WAIT: begin
				if (status.div_done) state_d = (pair_q == LAST_PAIR) ? ST_CORR : ST_CAL_START;
			end
			ST_CORR: begin
				state_d = ST_INTEG;
			end
			ST_INTEG: begin
				state_d = ST_YDIV_START;
			end
			ST_YDIV_START: begin
				state_d = ST_YDIV_WAIT;
			end
			ST_YDIV_WAIT: begin
				if (status.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ready  = 1'b1;
				cmd.load_item = sample_valid;
			end
			ST_UPDATE:     cmd.update     = 1'b1;
			ST_CAL_START:  cmd.cal_start  = 1'b1;
			ST_CAL_WAIT:   cmd.cal_write  = status.div_done;
			ST_CORR:       cmd.corr       = 1'b1;
			ST_INTEG:      cmd.integ      = 1'b1;
			ST_YDIV_START: cmd.ydiv_start = 1'b1;
			ST_YDIV_WAIT:  cmd.ydiv_write = status.div_done;
			ST_OUT:        cmd.out_load   = status.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/imuyaw_dp.sv -----
// ----------------------------------------------------------------------------
// imuyaw_dp
// datapath: configuration registers, calibration sums and offsets, yaw
// accumulators, two serial dividers, result register
// ----------------------------------------------------------------------------
module imuyaw_dp #(
	parameter int CALIB_SAMPLES = 256,
	parameter int CALIB_DISCARD = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  imuyaw_pkg::dp_cmd_t                    cmd,
	output imuyaw_pkg::dp_status_t                 status,
	input  imuyaw_pkg::sample_t                    sample,
	input  logic                                   cfg_we,
	input  logic [imuyaw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imuyaw_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output imuyaw_pkg::result_t                    result
);
	import imuyaw_pkg::*;

	localparam int                    AVG_N     = CALIB_SAMPLES - CALIB_DISCARD;
	localparam bit                    HAS_AVG   = AVG_N > 0;
	localparam logic [CNT_W-1:0]      DISCARD_C = CNT_W'(CALIB_DISCARD);
	localparam logic [CNT_W-1:0]      SAMPLES_C = CNT_W'(CALIB_SAMPLES);
	localparam logic [DIVISOR_W-1:0]  AVG_DIV   = DIVISOR_W'(HAS_AVG ? AVG_N : 1);

	// configuration
	logic [DB_W-1:0]             deadband_q;
	logic [DIVISOR_W-1:0]        divisor_q;
	logic signed [GAIN_W-1:0]    gain_q;

	// per-word state
	sample_t                     item_q;
	logic signed [AXIS_W-1:0]    raw_w [NUM_AXES];
	logic signed [AXIS_W-1:0]    corr_q [NUM_AXES];
	logic signed [AXIS_W-1:0]    offsets_q [NUM_AXES];
	logic signed [SUM_W-1:0]     sums_q [NUM_AXES];
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_inc_w;
	logic                        active_q;
	logic [YAW_W-1:0]            rel_raw_q;
	logic [YAW_W-1:0]            abs_raw_q;
	logic signed [YAW_W-1:0]     rel_q;
	logic signed [AXIS_W-1:0]    abs_low_q;

	logic                        is_sample_w;
	logic                        run_end_w;
	logic signed [AXIS_W:0]      gz_ext_w;
	logic signed [AXIS_W:0]      db_ext_w;
	logic                        past_db_w;
	logic signed [DELTA_W-1:0]   delta_w;
	logic [YAW_W-1:0]            delta_ext_w;
	logic                        integ_en_w;

	logic                        div_start_w;
	logic signed [YAW_W-1:0]     dvd0_w;
	logic signed [YAW_W-1:0]     dvd1_w;
	logic [DIVISOR_W-1:0]        dsr_w;
	logic [DIVISOR_W-1:0]        eff_div_w;
	logic                        done0_w;
	logic                        done1_w;
	logic signed [YAW_W-1:0]     quo0_w;
	logic signed [YAW_W-1:0]     quo1_w;

	logic signed [PROD_W-1:0]    prod_w;
	logic                        result_valid_q;
	result_t                     result_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			divisor_q  <= DIVISOR_RST;
			gain_q     <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEADBAND: deadband_q <= cfg_data[DB_W-1:0];
				REG_DIVISOR:  divisor_q  <= cfg_data[DIVISOR_W-1:0];
				REG_GAIN:     gain_q     <= signed'(cfg_data[GAIN_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= sample;
	end

	assign raw_w[0] = item_q.accel_x_raw;
	assign raw_w[1] = item_q.accel_y_raw;
	assign raw_w[2] = item_q.accel_z_raw;
	assign raw_w[3] = item_q.gyro_x_raw;
	assign raw_w[4] = item_q.gyro_y_raw;
	assign raw_w[5] = item_q.gyro_z_raw;

	assign is_sample_w = (item_q.cmd != CMD_START_CAL) && (item_q.cmd != CMD_RESET_REL);
	assign count_inc_w = count_q + 1'b1;
	assign run_end_w   = is_sample_w && active_q && (count_inc_w >= SAMPLES_C);

	assign status.cal_div  = run_end_w && HAS_AVG;
	assign status.div_done = done0_w;
	assign status.out_free = !result_valid_q || result_ready;

	// calibration state; offsets and sums shift by one pair per division round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sums_q[i]    <= '0;
				offsets_q[i] <= '0;
			end
		end else if (cmd.update) begin
			if (item_q.cmd == CMD_START_CAL) begin
				count_q  <= '0;
				active_q <= 1'b1;
				for (int i = 0; i < NUM_AXES; i++) sums_q[i] <= '0;
			end else if (is_sample_w && active_q) begin
				if (count_q >= DISCARD_C) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						sums_q[i] <= sums_q[i] + SUM_W'(raw_w[i]);
					end
				end
				count_q <= count_inc_w;
				if (run_end_w) begin
					active_q <= 1'b0;
					if (!HAS_AVG) begin
						for (int i = 0; i < NUM_AXES; i++) offsets_q[i] <= '0;
					end
				end
			end
		end else if (cmd.cal_write) begin
			for (int i = 0; i < NUM_AXES - 2; i++) begin
				sums_q[i]    <= sums_q[i+2];
				offsets_q[i] <= offsets_q[i+2];
			end
			offsets_q[NUM_AXES-2] <= quo0_w[AXIS_W-1:0];
			offsets_q[NUM_AXES-1] <= quo1_w[AXIS_W-1:0];
		end
	end

	// offset correction, 16-bit wrap
	always_ff @(posedge clk) begin
		if (cmd.corr) begin
			for (int i = 0; i < NUM_AXES; i++) corr_q[i] <= raw_w[i] - offsets_q[i];
		end
	end

	// deadband and integration step
	assign gz_ext_w    = (AXIS_W + 1)'(corr_q[NUM_AXES-1]);
	assign db_ext_w    = signed'({2'b00, deadband_q});
	assign past_db_w   = (gz_ext_w > db_ext_w) || (gz_ext_w < -db_ext_w);
	assign delta_w     = corr_q[NUM_AXES-1] * signed'({1'b0, item_q.step_time});
	assign delta_ext_w = YAW_W'(delta_w);
	assign integ_en_w  = cmd.integ && is_sample_w && !active_q && past_db_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_raw_q <= '0;
			abs_raw_q <= '0;
		end else if (cmd.update && item_q.cmd == CMD_RESET_REL) begin
			rel_raw_q <= '0;
		end else if (integ_en_w) begin
			rel_raw_q <= rel_raw_q + delta_ext_w;
			abs_raw_q <= abs_raw_q + delta_ext_w;
		end
	end

	// divider operands: offset averages or yaw scaling
	assign eff_div_w   = (divisor_q == '0) ? DIVISOR_W'(1) : divisor_q;
	assign div_start_w = cmd.cal_start || cmd.ydiv_start;
	assign dvd0_w      = cmd.cal_start ? sums_q[0] : signed'(rel_raw_q);
	assign dvd1_w      = cmd.cal_start ? sums_q[1] : signed'(abs_raw_q);
	assign dsr_w       = cmd.cal_start ? AVG_DIV : eff_div_w;

	imuyaw_div u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_w),
		.dividend (dvd0_w),
		.divisor  (dsr_w),
		.done     (done0_w),
		.quotient (quo0_w)
	);

	imuyaw_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_w),
		.dividend (dvd1_w),
		.divisor  (dsr_w),
		.done     (done1_w),
		.quotient (quo1_w)
	);

	always_ff @(posedge clk) begin
		if (cmd.ydiv_write && done1_w) begin
			rel_q     <= quo0_w;
			abs_low_q <= quo1_w[AXIS_W-1:0];
		end
	end

	// result register
	assign prod_w = rel_q * gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.accel_x_out         <= corr_q[0];
			result_q.accel_y_out         <= corr_q[1];
			result_q.accel_z_out         <= corr_q[2];
			result_q.gyro_x_out          <= corr_q[3];
			result_q.gyro_y_out          <= corr_q[4];
			result_q.gyro_z_out          <= corr_q[5];
			result_q.relative_yaw        <= rel_q;
			result_q.relative_yaw_scaled <= prod_w[YAW_W-1:0];
			result_q.absolute_yaw_low    <= abs_low_q;
			result_q.calibrating         <= active_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/imuyaw_chk.sv -----
// ----------------------------------------------------------------------------
// imuyaw_chk
// port-level checks on the top level, attached by bind
// ----------------------------------------------------------------------------
module imuyaw_chk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_ready,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  imuyaw_pkg::result_t  result
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// one word in flight: ready drops right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample accepted while a word is in flight");

	// a fresh result only appears at the end of a word's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!sample_ready))
		else $error("result appeared while idle");

	// no result can follow an accept in the very next cycle from an empty output
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && !result_valid |=> !result_valid)
		else $error("result appeared one cycle after accept");

endmodule

bind imu_bias_calibrate_yaw_integrate_unit imuyaw_chk u_imuyaw_chk (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the imu bias calibration and yaw integration unit:
// a behavioral predictor follows offsets, calibration runs and both yaw sums
// word by word, and every result word is compared field by field against it
// while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb;
	import imuyaw_pkg::*;

	localparam int CAL_SAMPLES   = 256;
	localparam int CAL_DISCARD   = 16;
	// longest correct silence is a run-ending word plus a sender gap and a
	// long result stall, so this leaves a wide margin
	localparam int QUIET_LIMIT   = 5000;
	// drain time after the last result, covers a run-ending word
	localparam int SETTLE_CYCLES = 200;

	// spare command code behaves as a plain sample
	localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
	// spare register index, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample_word  = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result_word;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	imu_bias_calibrate_yaw_integrate_unit #(
		.CALIB_SAMPLES(CAL_SAMPLES),
		.CALIB_DISCARD(CAL_DISCARD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor state: offsets, calibration sums and count, yaw accumulators
	// ------------------------------------------------------------------------
	logic [15:0]          bias_ofs [NUM_AXES];
	logic [31:0]          bias_sum [NUM_AXES];
	logic [10:0]          cal_count = '0;
	logic                 cal_on    = 1'b0;
	logic [31:0]          rel_acc   = '0;
	logic [31:0]          abs_acc   = '0;
	// register copies, start at their reset values
	logic [DB_W-1:0]      deadband  = DEADBAND_RST;
	logic [DIVISOR_W-1:0] divisor   = DIVISOR_RST;
	logic [GAIN_W-1:0]    gain      = GAIN_RST;

	// result words still owed by the block, oldest first
	result_t yaw_results_due [$];

	int mismatches   = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int idle_pct     = 33;
	int stall_left   = 0;

	// apply one accepted word to the predictor and return its result word
	function automatic result_t predict_imu_result(input sample_t w);
		logic [15:0] raw [NUM_AXES];
		logic [15:0] corr [NUM_AXES];
		logic [31:0] delta;
		longint      avg;
		longint      den;
		longint      rel_q;
		longint      abs_q;
		int          gz_val;
		int          db_val;
		result_t     r;
		raw[0] = w.accel_x_raw;
		raw[1] = w.accel_y_raw;
		raw[2] = w.accel_z_raw;
		raw[3] = w.gyro_x_raw;
		raw[4] = w.gyro_y_raw;
		raw[5] = w.gyro_z_raw;

		if (w.cmd == CMD_START_CAL) begin
			// (re)start a run: sums and count cleared, this word not counted
			for (int i = 0; i < NUM_AXES; i++)
				bias_sum[i] = '0;
			cal_count = '0;
			cal_on    = 1'b1;
		end else if (w.cmd == CMD_RESET_REL) begin
			rel_acc = '0;
		end else if (cal_on) begin
			// first words of a run are dropped, the rest summed per axis
			if (cal_count >= CAL_DISCARD) begin
				for (int i = 0; i < NUM_AXES; i++)
					bias_sum[i] = bias_sum[i] + {{16{raw[i][15]}}, raw[i]};
			end
			cal_count = cal_count + 1'b1;
			if (cal_count >= CAL_SAMPLES) begin
				// averages truncate toward zero
				for (int i = 0; i < NUM_AXES; i++) begin
					if (CAL_SAMPLES > CAL_DISCARD) begin
						avg = $signed(bias_sum[i]);
						avg = avg / (CAL_SAMPLES - CAL_DISCARD);
						bias_ofs[i] = avg[15:0];
					end else begin
						bias_ofs[i] = '0;
					end
				end
				cal_on = 1'b0;
			end
		end

		for (int i = 0; i < NUM_AXES; i++)
			corr[i] = raw[i] - bias_ofs[i];

		// plain samples outside a run integrate gyro z past the deadband,
		// including the word that just closed a run
		if (w.cmd != CMD_START_CAL && w.cmd != CMD_RESET_REL && !cal_on) begin
			gz_val = $signed(corr[5]);
			db_val = deadband;
			if (gz_val > db_val || gz_val < -db_val) begin
				delta   = 32'(gz_val * int'(w.step_time));
				rel_acc = rel_acc + delta;
				abs_acc = abs_acc + delta;
			end
		end

		// zero divisor acts as one
		den = divisor;
		if (den == 0)
			den = 1;
		rel_q = $signed(rel_acc);
		rel_q = rel_q / den;
		abs_q = $signed(abs_acc);
		abs_q = abs_q / den;

		r.accel_x_out         = corr[0];
		r.accel_y_out         = corr[1];
		r.accel_z_out         = corr[2];
		r.gyro_x_out          = corr[3];
		r.gyro_y_out          = corr[4];
		r.gyro_z_out          = corr[5];
		r.relative_yaw        = rel_q[31:0];
		r.relative_yaw_scaled = rel_q[31:0] * {{16{gain[15]}}, gain};
		r.absolute_yaw_low    = abs_q[15:0];
		r.calibrating         = cal_on;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// word builders
	// ------------------------------------------------------------------------
	function automatic sample_t pack_word(input logic [CMD_W-1:0] cmd, input int ax,
			input int ay, input int az, input int gx, input int gy, input int gz,
			input int st);
		sample_t w;
		w.cmd         = cmd;
		w.accel_x_raw = 16'(ax);
		w.accel_y_raw = 16'(ay);
		w.accel_z_raw = 16'(az);
		w.gyro_x_raw  = 16'(gx);
		w.gyro_y_raw  = 16'(gy);
		w.gyro_z_raw  = 16'(gz);
		w.step_time   = 8'(st);
		return w;
	endfunction

	// axis value leaning on the extremes
	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_step();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// sample code, now and then the spare one
	function automatic logic [CMD_W-1:0] sample_cmd();
		return ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_SAMPLE;
	endfunction

	function automatic sample_t rand_word(input logic [CMD_W-1:0] cmd);
		return pack_word(cmd, rand_axis(), rand_axis(), rand_axis(), rand_axis(),
			rand_axis(), rand_axis(), rand_step());
	endfunction

	// ------------------------------------------------------------------------
	// sample channel driver, called at a rising edge, returns at the accept
	// edge with valid still high so the caller can chain the next word
	// ------------------------------------------------------------------------
	task automatic send_word(input sample_t w);
		if ($urandom_range(0, 99) < idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 48)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		yaw_results_due.push_back(predict_imu_result(w));
	endtask

	// sender holds off until every owed result word has come back
	task automatic wait_for_results();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (yaw_results_due.size() != 0);
	endtask

	// write all registers while idle; upper data bits beyond a register's
	// width carry junk that must be ignored
	task automatic program_regs(input logic [DB_W-1:0] db, input logic [DIVISOR_W-1:0] div,
			input logic [GAIN_W-1:0] gn);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEADBAND;
		cfg_data  <= {5'($urandom), db};
		@(posedge clk);
		cfg_index <= REG_DIVISOR;
		cfg_data  <= div;
		@(posedge clk);
		cfg_index <= REG_GAIN;
		cfg_data  <= {4'($urandom), gn};
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= 20'($urandom);
		@(posedge clk);
		cfg_we   <= 1'b0;
		deadband = db;
		divisor  = div;
		gain     = gn;
	endtask

	// ------------------------------------------------------------------------
	// result channel: random stalls, sometimes long ones
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			result_ready <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 60);
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch on result word %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
	endtask

	task automatic check_result(input result_t got, input result_t want);
		if (got.accel_x_out !== want.accel_x_out)
			report_mismatch("accel_x_out", got.accel_x_out, want.accel_x_out);
		if (got.accel_y_out !== want.accel_y_out)
			report_mismatch("accel_y_out", got.accel_y_out, want.accel_y_out);
		if (got.accel_z_out !== want.accel_z_out)
			report_mismatch("accel_z_out", got.accel_z_out, want.accel_z_out);
		if (got.gyro_x_out !== want.gyro_x_out)
			report_mismatch("gyro_x_out", got.gyro_x_out, want.gyro_x_out);
		if (got.gyro_y_out !== want.gyro_y_out)
			report_mismatch("gyro_y_out", got.gyro_y_out, want.gyro_y_out);
		if (got.gyro_z_out !== want.gyro_z_out)
			report_mismatch("gyro_z_out", got.gyro_z_out, want.gyro_z_out);
		if (got.relative_yaw !== want.relative_yaw)
			report_mismatch("relative_yaw", got.relative_yaw, want.relative_yaw);
		if (got.relative_yaw_scaled !== want.relative_yaw_scaled)
			report_mismatch("relative_yaw_scaled", got.relative_yaw_scaled,
				want.relative_yaw_scaled);
		if (got.absolute_yaw_low !== want.absolute_yaw_low)
			report_mismatch("absolute_yaw_low", got.absolute_yaw_low, want.absolute_yaw_low);
		if (got.calibrating !== want.calibrating)
			report_mismatch("calibrating", got.calibrating, want.calibrating);
	endtask

	// every accepted result word against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (yaw_results_due.size() == 0)
				report_mismatch("result word with none owed", 1, 0);
			else
				check_result(result_word, yaw_results_due.pop_front());
			results_seen++;
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset register values: deadband edges, full-scale gyro z and steps,
	// spare code and relative yaw clear
	task automatic test_reset_defaults();
		send_word(pack_word(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
		send_word(pack_word(CMD_SAMPLE, 1, 2, 3, 4, 5, 19, 255));
		send_word(pack_word(CMD_SAMPLE, -1, -2, -3, -4, -5, -19, 255));
		send_word(pack_word(CMD_SAMPLE, 100, -100, 200, -200, 300, 20, 255));
		send_word(pack_word(CMD_SAMPLE, -32768, -32768, -32768, 32767, 32767, 32767, 255));
		send_word(pack_word(CMD_SPARE, 32767, 32767, 32767, -32768, -32768, -32768, 255));
		send_word(pack_word(CMD_RESET_REL, 12345, -12345, 1, -1, 0, 32767, 255));
		send_word(pack_word(CMD_SAMPLE, 0, 0, 0, 0, 0, -32768, 255));
	endtask

	// register extremes: zero deadband, zero divisor, full-scale gains,
	// deadband at its top so only the most negative gyro z passes
	task automatic test_register_extremes();
		wait_for_results();
		program_regs(15'd0, 20'd0, 16'h8000);
		send_word(pack_word(CMD_SAMPLE, 7, 7, 7, 7, 7, 1, 1));
		send_word(pack_word(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 255));
		send_word(pack_word(CMD_SAMPLE, 0, 0, 0, 0, 0, -1, 255));
		send_word(pack_word(CMD_SAMPLE, -9, 9, -9, 9, -9, 32767, 255));
		wait_for_results();
		program_regs(15'h7fff, 20'hfffff, 16'h7fff);
		send_word(pack_word(CMD_SAMPLE, 0, 0, 0, 0, 0, 32767, 255));
		send_word(pack_word(CMD_SAMPLE, 0, 0, 0, 0, 0, -32768, 255));
		send_word(pack_word(CMD_SPARE, 0, 0, 0, 0, 0, -32768, 0));
	endtask

	// start, discard-phase sample, relative clear during a run, restart
	task automatic test_calibration_commands();
		send_word(rand_word(CMD_START_CAL));
		send_word(rand_word(CMD_SAMPLE));
		send_word(rand_word(CMD_RESET_REL));
		send_word(rand_word(CMD_START_CAL));
		send_word(rand_word(CMD_SAMPLE));
		send_word(rand_word(CMD_SPARE));
	endtask

	// complete runs: steady bias with noise (no idling at all), full-range
	// noise with a restart halfway, and rails on every axis; a few relative
	// clears are sprinkled in and plain samples follow each run
	task automatic test_calibration_runs();
		logic [15:0] level [NUM_AXES];
		logic [15:0] ax [NUM_AXES];
		int          taken;
		bit          restarted;
		for (int run = 0; run < 3; run++) begin
			wait_for_results();
			program_regs(15'($urandom_range(0, 200)), 20'($urandom_range(1, 400000)),
				16'($urandom));
			idle_pct  = (run == 0) ? 0 : 33;
			restarted = 1'b0;
			for (int i = 0; i < NUM_AXES; i++)
				level[i] = (run == 2) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
					: 16'($urandom);
			send_word(rand_word(CMD_START_CAL));
			taken = 0;
			while (taken < CAL_SAMPLES) begin
				if ($urandom_range(0, 99) < 3) begin
					send_word(rand_word(CMD_RESET_REL));
				end else if (run == 1 && !restarted && taken == 120) begin
					send_word(rand_word(CMD_START_CAL));
					restarted = 1'b1;
					taken     = 0;
				end else begin
					for (int i = 0; i < NUM_AXES; i++) begin
						if (run == 1)
							ax[i] = rand_axis();
						else if (run == 2)
							ax[i] = level[i];
						else
							ax[i] = level[i] + 16'($urandom_range(0, 63)) - 16'd32;
					end
					send_word(pack_word(sample_cmd(), ax[0], ax[1], ax[2], ax[3], ax[4],
						ax[5], rand_step()));
					taken++;
				end
			end
			repeat (12)
				send_word(rand_word(sample_cmd()));
		end
		idle_pct = 33;
	endtask

	// random words under several register settings
	task automatic test_random_settings();
		for (int ph = 0; ph < 4; ph++) begin
			wait_for_results();
			case (ph)
				0: program_regs(15'd0, 20'd1, 16'h7fff);
				1: program_regs(15'h7fff, 20'hfffff, 16'h8000);
				2: program_regs(15'($urandom), 20'($urandom), 16'($urandom));
				default: program_regs(15'($urandom_range(0, 300)),
					20'($urandom_range(1, 5000)), 16'($urandom));
			endcase
			repeat (70) begin
				if ($urandom_range(0, 99) < 10)
					send_word(rand_word(CMD_RESET_REL));
				else
					send_word(rand_word(sample_cmd()));
			end
		end
	endtask

	// steady strong rotation with unit scale so both yaw sums wrap at 32 bits
	task automatic test_yaw_wrap();
		sample_t w;
		wait_for_results();
		program_regs(DEADBAND_RST, 20'd0, 16'($urandom));
		repeat (300) begin
			w            = rand_word(sample_cmd());
			w.gyro_z_raw = bias_ofs[5] + 16'($urandom_range(30000, 32767));
			w.step_time  = ($urandom_range(0, 9) == 0) ? rand_step() : 8'hff;
			send_word(w);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_AXES; i++) begin
			bias_ofs[i] = '0;
			bias_sum[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_calibration_commands();
		test_calibration_runs();
		test_random_settings();
		test_yaw_wrap();
		wait_for_results();
		// catch stray result words after the last owed one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
